/* hdl/cvln_pkg.sv */
// ----------------------------------------------------------------------------
// cvln_pkg: shared types and constants of the complex linear combination
// Formats, payload structs, register indexes and the controller command set.
// ----------------------------------------------------------------------------
package cvln_pkg;

	// element and coefficient format (signed, FRAC_W fraction bits)
	localparam int ELEM_W = 24;
	localparam int FRAC_W = 20;

	// product, exact sum of six products, rounded value before clipping
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = PROD_W + 3;
	localparam int RND_W  = SUM_W - FRAC_W;

	// squared magnitude of one part and the norm accumulator
	localparam int SQ_W   = PROD_W - 1;
	localparam int NORM_W = 63;

	// configuration port
	localparam int NUM_COEF = 6;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [NORM_W-1:0]        norm_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
	localparam elem_t COEF_ONE = elem_t'(1) <<< FRAC_W;
	localparam norm_t NORM_MAX = {NORM_W{1'b1}};

	// register indexes of the configuration port
	typedef enum cfg_idx_t {
		REG_COEF_A_RE = 3'd0,
		REG_COEF_A_IM = 3'd1,
		REG_COEF_B_RE = 3'd2,
		REG_COEF_B_IM = 3'd3,
		REG_COEF_C_RE = 3'd4,
		REG_COEF_C_IM = 3'd5,
		REG_NORM_EN   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		elem_t a_re;
		elem_t a_im;
		elem_t b_re;
		elem_t b_im;
		elem_t c_re;
		elem_t c_im;
		logic  last_in;
	} elem_item_t;

	typedef struct packed {
		elem_t new_re;
		elem_t new_im;
		logic  saturated;
		norm_t norm_sum;
		logic  last_out;
	} res_item_t;

	// coefficients in order a_re, a_im, b_re, b_im, c_re, c_im
	typedef struct packed {
		elem_t [NUM_COEF-1:0] coef;
		logic                 norm_en;
	} cfg_regs_t;

	// commands from the controller, one enable per datapath step
	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic rnd;
		logic sq;
		logic acc;
	} cvln_cmd_t;

endpackage

/* hdl/cvln_ifs.sv */
// ----------------------------------------------------------------------------
// cvln_ifs: handshake channels of the complex linear combination
// Element request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cvln_elem_if;
	import cvln_pkg::*;

	logic       valid;
	logic       ready;
	elem_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cvln_res_if;
	import cvln_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cvln_cfg_if;
	import cvln_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	elem_t    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* hdl/cvln_cfg.sv */
// ----------------------------------------------------------------------------
// cvln_cfg: configuration register file
// Holds the six coefficient parts and the norm enable; always takes writes.
// ----------------------------------------------------------------------------
module cvln_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  cvln_pkg::cfg_idx_t  wr_index,
	input  cvln_pkg::elem_t     wr_data,
	output cvln_pkg::cfg_regs_t regs
);
	import cvln_pkg::*;

	cfg_regs_t regs_q;

	// write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.coef    <= {{((NUM_COEF-1)*ELEM_W){1'b0}}, COEF_ONE};
			regs_q.norm_en <= 1'b0;
		end else if (wr_valid) begin
			case (wr_index)
				REG_COEF_A_RE: regs_q.coef[0] <= wr_data;
				REG_COEF_A_IM: regs_q.coef[1] <= wr_data;
				REG_COEF_B_RE: regs_q.coef[2] <= wr_data;
				REG_COEF_B_IM: regs_q.coef[3] <= wr_data;
				REG_COEF_C_RE: regs_q.coef[4] <= wr_data;
				REG_COEF_C_IM: regs_q.coef[5] <= wr_data;
				REG_NORM_EN:   regs_q.norm_en <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

/* hdl/cvln_ctrl.sv */
// ----------------------------------------------------------------------------
// cvln_ctrl: sequencing controller
// Walks one request through multiply, sum, round, square and accumulate,
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module cvln_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cvln_pkg::cvln_cmd_t cmd
);
	import cvln_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_ADD  = 6'b000100,
		ST_RND  = 6'b001000,
		ST_SQ   = 6'b010000,
		ST_ACC  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   res_free;

	// the result register can be loaded when empty or being drained
	assign res_free = !out_valid_q || out_ready;

	// next state and step commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (res_free) begin
					cmd.acc = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// advance state, set result valid on load, clear it on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hdl/cvln_dp.sv */
// ----------------------------------------------------------------------------
// cvln_dp: arithmetic datapath
// Complex products, exact sum, round and clip, squared magnitude and the
// saturating norm accumulator; each step is enabled by a controller command.
// ----------------------------------------------------------------------------
module cvln_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cvln_pkg::cvln_cmd_t  cmd,
	input  cvln_pkg::elem_item_t in_data,
	input  cvln_pkg::cfg_regs_t  regs,
	output cvln_pkg::res_item_t  res_data
);
	import cvln_pkg::*;

	typedef struct packed {
		elem_t v;
		logic  sat;
	} rnd_res_t;

	// round a sum of products to nearest, ties up, then clip
	function automatic rnd_res_t round_clip(input sum_t s);
		sum_t     t;
		rnd_t     r;
		rnd_res_t o;
		t = s + (sum_t'(1) <<< (FRAC_W - 1));
		r = $signed(t[SUM_W-1:FRAC_W]);
		if (r > rnd_t'(ELEM_MAX)) begin
			o.v   = ELEM_MAX;
			o.sat = 1'b1;
		end else if (r < rnd_t'(ELEM_MIN)) begin
			o.v   = ELEM_MIN;
			o.sat = 1'b1;
		end else begin
			o.v   = r[ELEM_W-1:0];
			o.sat = 1'b0;
		end
		return o;
	endfunction

	elem_t [NUM_COEF-1:0] x_q;
	logic                 last_q;
	prod_t [NUM_COEF-1:0] prod_re_s1;
	prod_t [NUM_COEF-1:0] prod_im_s1;
	sum_t                 sum_re_s2;
	sum_t                 sum_im_s2;
	elem_t                re_s3;
	elem_t                im_s3;
	logic                 sat_s3;
	sq_t                  sq_re_s4;
	sq_t                  sq_im_s4;
	norm_t                acc_q;
	res_item_t            res_q;

	sum_t                 sum_re_d;
	sum_t                 sum_im_d;
	rnd_res_t             rnd_re;
	rnd_res_t             rnd_im;
	prod_t                sqp_re;
	prod_t                sqp_im;
	logic [NORM_W:0]      acc_tot;
	norm_t                acc_new;

	// hold the request operands
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[0] <= in_data.a_re;
			x_q[1] <= in_data.a_im;
			x_q[2] <= in_data.b_re;
			x_q[3] <= in_data.b_im;
			x_q[4] <= in_data.c_re;
			x_q[5] <= in_data.c_im;
			last_q <= in_data.last_in;
		end
	end

	// four partial products per complex term
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int k = 0; k < NUM_COEF / 2; k++) begin
				prod_re_s1[2*k]   <= prod_t'(regs.coef[2*k]) * prod_t'(x_q[2*k]);
				prod_re_s1[2*k+1] <= -(prod_t'(regs.coef[2*k+1]) * prod_t'(x_q[2*k+1]));
				prod_im_s1[2*k]   <= prod_t'(regs.coef[2*k]) * prod_t'(x_q[2*k+1]);
				prod_im_s1[2*k+1] <= prod_t'(regs.coef[2*k+1]) * prod_t'(x_q[2*k]);
			end
		end
	end

	// exact sum of the six products of each part
	always_comb begin
		sum_re_d = '0;
		sum_im_d = '0;
		for (int k = 0; k < NUM_COEF; k++) begin
			sum_re_d = sum_re_d + sum_t'(prod_re_s1[k]);
			sum_im_d = sum_im_d + sum_t'(prod_im_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			sum_re_s2 <= sum_re_d;
			sum_im_s2 <= sum_im_d;
		end
	end

	// round and clip both parts
	assign rnd_re = round_clip(sum_re_s2);
	assign rnd_im = round_clip(sum_im_s2);

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			re_s3  <= rnd_re.v;
			im_s3  <= rnd_im.v;
			sat_s3 <= rnd_re.sat | rnd_im.sat;
		end
	end

	// squares of the clipped parts
	assign sqp_re = prod_t'(re_s3) * prod_t'(re_s3);
	assign sqp_im = prod_t'(im_s3) * prod_t'(im_s3);

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			sq_re_s4 <= sqp_re[SQ_W-1:0];
			sq_im_s4 <= sqp_im[SQ_W-1:0];
		end
	end

	// add the squared magnitude when enabled, clip at the top
	always_comb begin
		acc_tot = {1'b0, acc_q};
		if (regs.norm_en) begin
			acc_tot = acc_tot + (NORM_W + 1)'(sq_re_s4) + (NORM_W + 1)'(sq_im_s4);
		end
		acc_new = acc_tot[NORM_W] ? NORM_MAX : acc_tot[NORM_W-1:0];
	end

	// update the accumulator, clear it at the end of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= last_q ? '0 : acc_new;
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			res_q.new_re    <= re_s3;
			res_q.new_im    <= im_s3;
			res_q.saturated <= sat_s3;
			res_q.norm_sum  <= last_q ? acc_new : '0;
			res_q.last_out  <= last_q;
		end
	end

	assign res_data = res_q;

endmodule

/* hdl/complex_vector_lincomb_norm_top.sv */
// ----------------------------------------------------------------------------
// complex_vector_lincomb_norm_top: complex linear combination with norm
// Computes new = ka*a + kb*b + kc*c per element and sums |new|^2 per vector.
// ----------------------------------------------------------------------------
// Usage:
//   elem carries one element of a, b and c plus last_in; res returns the
//   rounded, clipped element, the clip flag, and on the last element the
//   saturating sum of squared magnitudes (zero on other elements).
//   cfg writes coefficients and the norm enable by index; it is always
//   ready and must only be used while no element is in flight.
//   An element is taken only when elem is ready, that is while the
//   controller is idle; it steps the element through multiply, sum,
//   round/clip, square and accumulate, one registered step per cycle
//   while the result register is free. The result becomes valid when
//   the accumulate step loads it, and the next element is taken after that.
//   The result register keeps its data while res.ready is low; the next
//   element still advances up to the accumulate step and waits there.
//   Reset sets coef_a to 1.0, the other coefficients and the norm enable to
//   zero, clears the norm sum and empties the result register.
// ----------------------------------------------------------------------------
module complex_vector_lincomb_norm_top (
	input logic      clk,
	input logic      arst_n,
	cvln_elem_if.sink  elem,
	cvln_res_if.source res,
	cvln_cfg_if.sink   cfg
);
	import cvln_pkg::*;

	cfg_regs_t regs;
	cvln_cmd_t cmd;

	assign cfg.ready = 1'b1;

	cvln_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs)
	);

	cvln_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (elem.valid),
		.in_ready  (elem.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd)
	);

	cvln_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (elem.data),
		.regs     (regs),
		.res_data (res.data)
	);

endmodule

/* bench/complex_vector_lincomb_norm_top_test.sv */
// ----------------------------------------------------------------------------
// complex_vector_lincomb_norm_top_test: self-checking bench of the lincomb block
// Streams element requests, predicts each rounded and clipped combination and
// the per-vector sum of squared magnitudes, and compares every result field.
// Coefficients and the norm enable change between phases while idle.
// ----------------------------------------------------------------------------
module complex_vector_lincomb_norm_top_test;
	import cvln_pkg::*;

	localparam cfg_idx_t IDX_UNUSED   = 3'd7;
	localparam int       HOLD_CYCLES  = 400;
	localparam int       STALL_LIMIT  = 5000;
	localparam int       PHASES       = 12;
	localparam int       PHASE_ITEMS  = 110;
	localparam int       SAT_VEC_LEN  = 24;

	logic clk = 1'b0;
	logic arst_n;

	cvln_elem_if elem_ch();
	cvln_res_if  res_ch();
	cvln_cfg_if  cfg_ch();

	complex_vector_lincomb_norm_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.elem(elem_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// copy of the block's registers and norm state
	elem_t       coef_shadow [NUM_COEF];
	logic        norm_enabled;
	logic [63:0] norm_acc;

	elem_item_t element_queue[$];
	res_item_t  awaited_updates[$];

	int src_idle_pct;
	int sink_idle_pct;
	int mismatches;
	int quiet_cycles;
	bit hold_req;
	bit hold_ack;
	int hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clip a rounded sum to the element range, flag when clipped
	function automatic elem_t clip_elem(longint v, inout bit sat);
		if (v > longint'(ELEM_MAX)) begin
			sat = 1'b1;
			return ELEM_MAX;
		end
		if (v < longint'(ELEM_MIN)) begin
			sat = 1'b1;
			return ELEM_MIN;
		end
		return elem_t'(v);
	endfunction

	// new = ka*a + kb*b + kc*c, rounded half up, clipped; update the norm sum
	function automatic res_item_t combine_element(elem_item_t it);
		longint kar, kai, kbr, kbi, kcr, kci;
		longint re_sum, im_sum, half, sq;
		logic [63:0] acc_next;
		bit sat;
		res_item_t r;
		kar = coef_shadow[REG_COEF_A_RE];
		kai = coef_shadow[REG_COEF_A_IM];
		kbr = coef_shadow[REG_COEF_B_RE];
		kbi = coef_shadow[REG_COEF_B_IM];
		kcr = coef_shadow[REG_COEF_C_RE];
		kci = coef_shadow[REG_COEF_C_IM];
		re_sum = kar * longint'(it.a_re) - kai * longint'(it.a_im)
			+ kbr * longint'(it.b_re) - kbi * longint'(it.b_im)
			+ kcr * longint'(it.c_re) - kci * longint'(it.c_im);
		im_sum = kar * longint'(it.a_im) + kai * longint'(it.a_re)
			+ kbr * longint'(it.b_im) + kbi * longint'(it.b_re)
			+ kcr * longint'(it.c_im) + kci * longint'(it.c_re);
		half = longint'(1) <<< (FRAC_W - 1);
		sat = 1'b0;
		r.new_re = clip_elem((re_sum + half) >>> FRAC_W, sat);
		r.new_im = clip_elem((im_sum + half) >>> FRAC_W, sat);
		r.saturated = sat;
		if (norm_enabled) begin
			sq = longint'(r.new_re) * longint'(r.new_re)
				+ longint'(r.new_im) * longint'(r.new_im);
			acc_next = norm_acc + 64'(sq);
			norm_acc = (acc_next > 64'(NORM_MAX)) ? 64'(NORM_MAX) : acc_next;
		end
		r.last_out = it.last_in;
		r.norm_sum = it.last_in ? norm_acc[NORM_W-1:0] : '0;
		if (it.last_in)
			norm_acc = '0;
		return r;
	endfunction

	function automatic elem_t pick_elem();
		case ($urandom_range(0, 9))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return '0;
			3: return elem_t'(int'($urandom_range(0, 1 << (FRAC_W + 1))) - (1 << FRAC_W));
			default: return elem_t'($urandom);
		endcase
	endfunction

	function automatic elem_t pick_coef();
		case ($urandom_range(0, 9))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return COEF_ONE;
			3: return elem_t'(-COEF_ONE);
			4: return '0;
			5: return elem_t'($urandom);
			default: return elem_t'(int'($urandom_range(0, 1 << (FRAC_W + 1))) - (1 << FRAC_W));
		endcase
	endfunction

	// random upper bits, the enable in bit zero
	function automatic elem_t enable_word(bit en);
		elem_t w;
		w = elem_t'($urandom);
		w[0] = en;
		return w;
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_result(res_item_t got);
		res_item_t want;
		if (awaited_updates.size() == 0) begin
			note_mismatch($sformatf("result with none awaited: re %0d im %0d",
				got.new_re, got.new_im));
			return;
		end
		want = awaited_updates.pop_front();
		if (got.new_re !== want.new_re)
			note_mismatch($sformatf("new_re expected %0d got %0d", want.new_re, got.new_re));
		if (got.new_im !== want.new_im)
			note_mismatch($sformatf("new_im expected %0d got %0d", want.new_im, got.new_im));
		if (got.saturated !== want.saturated)
			note_mismatch($sformatf("saturated expected %0b got %0b",
				want.saturated, got.saturated));
		if (got.norm_sum !== want.norm_sum)
			note_mismatch($sformatf("norm_sum expected %0d got %0d",
				want.norm_sum, got.norm_sum));
		if (got.last_out !== want.last_out)
			note_mismatch($sformatf("last_out expected %0b got %0b",
				want.last_out, got.last_out));
	endtask

	// write one register, mirror it once the write is taken
	task automatic write_reg(cfg_idx_t idx, elem_t value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx < NUM_COEF)
			coef_shadow[idx] = value;
		else if (idx == REG_NORM_EN)
			norm_enabled = value[0];
	endtask

	// hold until nothing is queued, offered or awaited
	task automatic wait_idle();
		do @(negedge clk);
		while (element_queue.size() != 0 || elem_ch.valid || awaited_updates.size() != 0);
	endtask

	task automatic push_item(elem_t ar, elem_t ai, bit last);
		elem_item_t it;
		it.a_re = ar;
		it.a_im = ai;
		it.b_re = pick_elem();
		it.b_im = pick_elem();
		it.c_re = pick_elem();
		it.c_im = pick_elem();
		it.last_in = last;
		element_queue.push_back(it);
	endtask

	// queue random elements grouped in vectors; a vector may span phases
	task automatic queue_random(int n, inout int vec_left);
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			if (vec_left == 0)
				vec_left = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
			push_item(pick_elem(), pick_elem(), vec_left == 1);
			vec_left--;
		end
	endtask

	// sender: offer queued requests, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_ch.valid <= 1'b0;
			elem_ch.data <= '0;
		end else begin
			if (elem_ch.valid && elem_ch.ready)
				awaited_updates.push_back(combine_element(elem_ch.data));
			if (!elem_ch.valid || elem_ch.ready) begin
				if (element_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					elem_ch.valid <= 1'b1;
					elem_ch.data <= element_queue.pop_front();
				end else begin
					elem_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check taken results, stall at random or for a long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_ack <= 1'b0;
			hold_left <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				check_result(res_ch.data);
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int vec_left;
		int split;
		elem_t ext_re;
		elem_t ext_im;
		arst_n = 1'b0;
		elem_ch.valid = 1'b0;
		elem_ch.data = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		mismatches = 0;
		vec_left = 0;
		src_idle_pct = 18;
		sink_idle_pct = 61;
		foreach (coef_shadow[i])
			coef_shadow[i] = '0;
		coef_shadow[REG_COEF_A_RE] = COEF_ONE;
		norm_enabled = 1'b0;
		norm_acc = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: pass a through, norm off reports zero
		@(negedge clk);
		push_item(ELEM_MAX, ELEM_MIN, 1'b0);
		push_item(ELEM_MIN, ELEM_MAX, 1'b0);
		push_item('0, '0, 1'b1);
		push_item(pick_elem(), pick_elem(), 1'b1);

		// half coefficient: ties round toward plus infinity; bad index ignored
		wait_idle();
		write_reg(REG_COEF_A_RE, COEF_ONE >>> 1);
		write_reg(REG_NORM_EN, enable_word(1'b1));
		write_reg(IDX_UNUSED, elem_t'($urandom));
		@(negedge clk);
		push_item(elem_t'(1), elem_t'(-1), 1'b0);
		push_item(elem_t'(3), elem_t'(-3), 1'b0);
		push_item(elem_t'(-3), elem_t'(3), 1'b0);
		push_item(ELEM_MAX, ELEM_MIN, 1'b1);

		// extreme coefficients: clip both ways, leave the vector open
		wait_idle();
		write_reg(REG_COEF_A_RE, ELEM_MIN);
		write_reg(REG_COEF_A_IM, ELEM_MAX);
		write_reg(REG_COEF_B_RE, ELEM_MAX);
		write_reg(REG_COEF_B_IM, ELEM_MIN);
		write_reg(REG_COEF_C_RE, ELEM_MIN);
		write_reg(REG_COEF_C_IM, ELEM_MIN);
		@(negedge clk);
		push_item(ELEM_MIN, ELEM_MIN, 1'b0);
		push_item(ELEM_MAX, ELEM_MAX, 1'b0);
		push_item(ELEM_MAX, ELEM_MIN, 1'b0);

		// norm off: the last element still reports what was summed before
		wait_idle();
		write_reg(REG_NORM_EN, enable_word(1'b0));
		@(negedge clk);
		push_item(ELEM_MIN, ELEM_MAX, 1'b0);
		push_item(pick_elem(), pick_elem(), 1'b1);

		// random phases with fresh settings each
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES / 3) begin
				src_idle_pct = 61;
				sink_idle_pct = 18;
			end else if (ph == 2 * PHASES / 3) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			wait_idle();
			for (int r = 0; r < NUM_COEF; r++)
				write_reg(cfg_idx_t'(r), pick_coef());
			write_reg(REG_NORM_EN, enable_word($urandom_range(0, 3) != 0));
			if (ph == 1) begin
				@(negedge clk);
				hold_req = !hold_req;
			end
			split = $urandom_range(20, 90);
			queue_random(split, vec_left);
			// pause the sender until every result is back
			if (ph % 4 == 2)
				wait_idle();
			queue_random(PHASE_ITEMS - split, vec_left);
		end

		// one vector of full-scale results builds a large norm sum
		wait_idle();
		write_reg(REG_COEF_A_RE, COEF_ONE);
		write_reg(REG_COEF_A_IM, '0);
		write_reg(REG_COEF_B_RE, '0);
		write_reg(REG_COEF_B_IM, '0);
		write_reg(REG_COEF_C_RE, '0);
		write_reg(REG_COEF_C_IM, '0);
		write_reg(REG_NORM_EN, enable_word(1'b1));
		@(negedge clk);
		for (int i = 0; i < SAT_VEC_LEN; i++) begin
			ext_re = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
			ext_im = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
			push_item(ext_re, ext_im, i == SAT_VEC_LEN - 1);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		mismatches += awaited_updates.size();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* complex_vector_lincomb_norm_top.f */
hdl/cvln_pkg.sv
hdl/cvln_ifs.sv
hdl/cvln_cfg.sv
hdl/cvln_ctrl.sv
hdl/cvln_dp.sv
hdl/complex_vector_lincomb_norm_top.sv
bench/complex_vector_lincomb_norm_top_test.sv
